>>> sv/mam_pkg.sv
// Shared types, constants and the microprogram of the 3x3 matrix add/multiply block.
package mam_pkg;

  localparam int DIM = 3;
  localparam int NELEM = DIM * DIM;
  localparam int IDX_W = 2;
  localparam int ADDR_W = 4;
  localparam int VAL_W = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int UPC_W = 3;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam upc_t STEP_IDLE      = 3'd0;
  localparam upc_t STEP_WRITE     = 3'd1;
  localparam upc_t STEP_SHOW_A    = 3'd2;
  localparam upc_t STEP_SHOW_SUM  = 3'd3;
  localparam upc_t STEP_MUL       = 3'd4;
  localparam upc_t STEP_ACC       = 3'd5;
  localparam upc_t STEP_SHOW_PROD = 3'd6;

  typedef enum logic [1:0] {
    SRC_A,
    SRC_SUM,
    SRC_ACC
  } src_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_K_MORE,
    JMP_ELEM_MORE
  } jmp_t;

  typedef struct packed {
    logic wait_in;
    logic write_a;
    logic emit;
    src_t src;
    logic mul;
    logic acc;
    jmp_t jmp;
    upc_t target;
  } cw_t;

  typedef struct packed {
    cw_t  cw;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic k_last;
    logic elem_last;
    logic out_hold;
  } stat_t;

  function automatic cw_t urom(upc_t upc);
    cw_t w;
    w = '{wait_in: 1'b0, write_a: 1'b0, emit: 1'b0, src: SRC_A, mul: 1'b0,
          acc: 1'b0, jmp: JMP_NEXT, target: STEP_IDLE};
    case (upc)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
      end
      STEP_WRITE: begin
        w.write_a = 1'b1;
        w.jmp = JMP_ALWAYS;
        w.target = STEP_SHOW_A;
      end
      STEP_SHOW_A: begin
        w.emit = 1'b1;
        w.src = SRC_A;
        w.jmp = JMP_ELEM_MORE;
        w.target = STEP_SHOW_A;
      end
      STEP_SHOW_SUM: begin
        w.emit = 1'b1;
        w.src = SRC_SUM;
        w.jmp = JMP_ELEM_MORE;
        w.target = STEP_SHOW_SUM;
      end
      STEP_MUL: begin
        w.mul = 1'b1;
      end
      STEP_ACC: begin
        w.acc = 1'b1;
        w.jmp = JMP_K_MORE;
        w.target = STEP_MUL;
      end
      STEP_SHOW_PROD: begin
        w.emit = 1'b1;
        w.src = SRC_ACC;
        w.jmp = JMP_ELEM_MORE;
        w.target = STEP_MUL;
      end
      default: begin
        w.jmp = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // The fixed matrix holds 1 through NELEM in row-major order.
  function automatic val_t b_val(addr_t idx);
    val_t v;
    v = '0;
    if (int'(idx) < NELEM) begin
      v = VAL_W'(idx) + val_t'(1);
    end
    return v;
  endfunction

endpackage

>>> sv/mam_seq.sv
// Microcode sequencer: step counter, control store lookup, stalls and jumps.
module mam_seq
  import mam_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  input  stat_t      st,
  output ctl_t       ctl,
  output logic       in_ready
);

  upc_t upc;
  upc_t upc_next;
  cw_t  cw;
  logic stall;

  assign cw = urom(upc);
  assign stall = (cw.wait_in && !in_valid) || (cw.emit && st.out_hold);
  assign ctl.cw = cw;
  assign ctl.fire = !stall;
  assign in_ready = cw.wait_in;

  always_comb begin
    upc_next = upc;
    if (!stall) begin
      if (cw.wait_in) begin
        case (opcode)
          OP_SET:  upc_next = STEP_WRITE;
          OP_ADD:  upc_next = STEP_SHOW_SUM;
          OP_MUL:  upc_next = STEP_MUL;
          default: upc_next = STEP_IDLE;
        endcase
      end else begin
        case (cw.jmp)
          JMP_NEXT:      upc_next = upc + upc_t'(1);
          JMP_ALWAYS:    upc_next = cw.target;
          JMP_K_MORE:    upc_next = st.k_last ? upc + upc_t'(1) : cw.target;
          JMP_ELEM_MORE: upc_next = st.elem_last ? STEP_IDLE : cw.target;
          default:       upc_next = STEP_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> sv/mam_dp.sv
// Datapath: matrix A, element counters, multiply-accumulate and output register.
module mam_dp
  import mam_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  input  val_t in_value,
  input  idx_t in_row,
  input  idx_t in_col,
  output stat_t st,
  output logic out_valid,
  input  logic out_ready,
  output idx_t out_row,
  output idx_t out_col,
  output val_t out_value,
  output logic out_last
);

  val_t  a [NELEM];
  idx_t  r;
  idx_t  c;
  idx_t  k;
  val_t  wr_value;
  idx_t  wr_row;
  idx_t  wr_col;
  val_t  prod;
  val_t  acc;
  addr_t a_addr;
  addr_t b_addr;
  addr_t wr_addr;
  val_t  a_rd;
  val_t  b_rd;
  val_t  res;
  logic  elem_last;
  logic  k_last;

  assign elem_last = (r == idx_t'(DIM - 1)) && (c == idx_t'(DIM - 1));
  assign k_last = (k == idx_t'(DIM - 1));
  assign st.k_last = k_last;
  assign st.elem_last = elem_last;
  assign st.out_hold = out_valid && !out_ready;

  always_comb begin
    if (ctl.cw.mul) begin
      a_addr = addr_t'(r) * addr_t'(DIM) + addr_t'(k);
      b_addr = addr_t'(k) * addr_t'(DIM) + addr_t'(c);
    end else begin
      a_addr = addr_t'(r) * addr_t'(DIM) + addr_t'(c);
      b_addr = a_addr;
    end
  end

  assign wr_addr = addr_t'(wr_row) * addr_t'(DIM) + addr_t'(wr_col);
  assign a_rd = (int'(a_addr) < NELEM) ? a[a_addr] : '0;
  assign b_rd = b_val(b_addr);

  always_comb begin
    case (ctl.cw.src)
      SRC_A:   res = a_rd;
      SRC_SUM: res = a_rd + b_rd;
      SRC_ACC: res = acc;
      default: res = a_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NELEM; i++) begin
        a[i] <= VAL_W'(i + 1);
      end
    end else if (ctl.fire && ctl.cw.write_a) begin
      if ((int'(wr_row) < DIM) && (int'(wr_col) < DIM)) begin
        a[wr_addr] <= wr_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.cw.wait_in) begin
      wr_value <= in_value;
      wr_row <= in_row;
      wr_col <= in_col;
    end
    if (ctl.fire && ctl.cw.mul) begin
      prod <= VAL_W'(a_rd * b_rd);
    end
    if (ctl.fire && ctl.cw.acc) begin
      acc <= (k == '0) ? prod : acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
      k <= '0;
    end else if (ctl.fire) begin
      if (ctl.cw.acc) begin
        k <= k_last ? '0 : k + idx_t'(1);
      end
      if (ctl.cw.emit) begin
        if (c == idx_t'(DIM - 1)) begin
          c <= '0;
          r <= elem_last ? '0 : r + idx_t'(1);
        end else begin
          c <= c + idx_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire && ctl.cw.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.cw.emit) begin
      out_row <= r;
      out_col <= c;
      out_value <= res;
      out_last <= elem_last;
    end
  end

endmodule

>>> sv/matrix_add_multiply_3x3_core.sv
// Top level of the 3x3 matrix add/multiply block.
//
// The block holds a writable 3x3 matrix A (1..9 row-major after reset) and a
// fixed matrix B (1..9). Each item on the slave stream carries an opcode:
// set one element of A and show A, show A+B, or show A*B. An unused opcode is
// taken and produces nothing. Every command produces nine items on the master
// stream in row-major order, with tlast on the ninth. Arithmetic wraps at 32 bits.
// A short microprogram steps a shared datapath one element at a time.
// Show A and A+B emit one element per cycle while the master stream takes
// them. The product runs three multiplies and three accumulates on one
// multiplier plus the emit step for each element.
// For A+B the first item is registered in the first sum step, a write first
// updates A in its write step, and the product first runs its multiply and
// accumulate steps.
// s_tready is high only while the sequencer waits for a command.
// A stalled master stream freezes the sequencer at its emit step, and the output
// register holds its item until it is taken.
// Reset restores A to 1..9, clears the output valid flag and returns to waiting.
module matrix_add_multiply_3x3_core
  import mam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // opcode[1:0], elem_value[33:2], row_index[35:34], col_index[37:36], zeros above
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_row[1:0], out_col[3:2], out_value[35:4], zeros above
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  ctl_t ctl;
  stat_t st;
  idx_t out_row;
  idx_t out_col;
  val_t out_value;

  mam_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .opcode   (s_tdata[1:0]),
    .st       (st),
    .ctl      (ctl),
    .in_ready (s_tready)
  );

  mam_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_value  (s_tdata[33:2]),
    .in_row    (s_tdata[35:34]),
    .in_col    (s_tdata[37:36]),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_value, out_col, out_row};

endmodule

>>> sv/mam_check.sv
// Port-level checker for the matrix block, bound to the top level.
module mam_check
  import mam_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[1:0] == 2'd2) && (m_tdata[3:2] == 2'd2))
    else $error("The last item of a run is not the bottom right element.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("A stalled output item changed.");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:36] == 4'd0))
    else $error("Output padding bits are not zero.");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[1:0] != OP_NONE) |=> !s_tready)
    else $error("The block took a new item right after a command.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("The output is valid right after reset.");

endmodule

bind matrix_add_multiply_3x3_core mam_check u_mam_check (.*);
